// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam int CH_IN_W   = 4;
  localparam int SAMPLE_W  = 16;
  localparam int VAL_W     = 32;
  localparam int WEIGHT_W  = 17;
  localparam int SCALE_W   = 16;
  localparam int CFG_ADR_W = 3;
  localparam int CFG_DAT_W = 17;
  localparam int OUT_DAT_W = 88;

  // Multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SAT_IN_W = 48;

  localparam logic [WEIGHT_W-1:0] ONE_Q16       = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 17'd65536;
  localparam logic [SCALE_W-1:0]  SCALE_RST     = 16'd1280;
  localparam logic                EN_RAW_RST    = 1'b1;
  localparam logic                EN_FIRST_RST  = 1'b1;
  localparam logic                EN_SECOND_RST = 1'b0;

  typedef enum logic [CFG_ADR_W-1:0] {
    REG_WEIGHT    = 3'd0,
    REG_SCALE     = 3'd1,
    REG_EN_RAW    = 3'd2,
    REG_EN_FIRST  = 3'd3,
    REG_EN_SECOND = 3'd4
  } ssd_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_NOW,
    S_D1,
    S_D2,
    S_DONE
  } ssd_state_e;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(signed'(32'h7fff_ffff));
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/smoothed_sensor_derivatives.sv =====
// An accepted input word passes through states LOAD, NOW, D1, D2 and DONE to the result
// register, and DONE holds while the output is stalled. The block is busy meanwhile.
// One shared 34x18 multiplier is used three times per word (smoothing, first, second
// difference), with a history RAM read before it and a saturating add after smoothing.
// Reset: config registers take their defaults, per-channel valid bits clear so all
// history reads as zero at once; the RAM itself needs no clearing pass.
module smoothed_sensor_derivatives #(
  parameter int CHANNELS = ssd_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CFG_ADR_W-1:0]  cfg_addr_i,
  input  logic [ssd_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ssd_pkg::SAMPLE_W-1:0]   s_axis_tdata_i,  // [15:0] sample
  input  logic [ssd_pkg::CH_IN_W-1:0]    s_axis_tuser_i,  // [3:0] channel
  // output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [15:0] raw_value, [16] raw_valid, [48:17] first_deriv, [49] first_valid,
  // [81:50] second_deriv, [82] second_valid, [87:83] zero
  output logic [ssd_pkg::OUT_DAT_W-1:0]  m_axis_tdata_o,
  output logic [ssd_pkg::CH_IN_W-1:0]    m_axis_tuser_o   // [3:0] out_channel
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAM_W = 2 * ssd_pkg::VAL_W;
  localparam int VW    = ssd_pkg::VAL_W;
  localparam int AW    = ssd_pkg::MUL_A_W;
  localparam int PW    = ssd_pkg::PROD_W;

  // config registers
  logic [ssd_pkg::WEIGHT_W-1:0] weight_q;
  logic [ssd_pkg::SCALE_W-1:0]  scale_q;
  logic                         en_raw_q, en_first_q, en_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= ssd_pkg::WEIGHT_RST;
      scale_q     <= ssd_pkg::SCALE_RST;
      en_raw_q    <= ssd_pkg::EN_RAW_RST;
      en_first_q  <= ssd_pkg::EN_FIRST_RST;
      en_second_q <= ssd_pkg::EN_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ssd_pkg::REG_WEIGHT:    weight_q    <= cfg_wdata_i;
        ssd_pkg::REG_SCALE:     scale_q     <= cfg_wdata_i[ssd_pkg::SCALE_W-1:0];
        ssd_pkg::REG_EN_RAW:    en_raw_q    <= cfg_wdata_i[0];
        ssd_pkg::REG_EN_FIRST:  en_first_q  <= cfg_wdata_i[0];
        ssd_pkg::REG_EN_SECOND: en_second_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  ssd_pkg::ssd_state_e state_q, state_d;

  logic                          in_acc, out_free, out_load;
  logic [8:0]                    ch_ext;
  logic                          in_range_d;
  logic [CH_W-1:0]               addr_q;
  logic                          in_range_q;
  logic [ssd_pkg::CH_IN_W-1:0]   ch_q;
  logic signed [ssd_pkg::SAMPLE_W-1:0] samp_q;

  logic [CHANNELS-1:0]           chan_vld_q;
  logic [RAM_W-1:0]              ram_rdata;
  logic                          ram_we;

  logic signed [VW-1:0]          last_q, before_q, now_q, d1_q;
  logic signed [VW-1:0]          last_d, before_d, now_d, d2_d;
  logic signed [VW-1:0]          samp_fx;
  logic [ssd_pkg::WEIGHT_W-1:0]  eps;

  logic signed [AW-1:0]                mul_a;
  logic signed [ssd_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [PW-1:0]                prod_d, prod_q;
  logic signed [PW-1:0]                rs16, rs8;

  logic                          out_vld_q;
  logic [ssd_pkg::OUT_DAT_W-1:0] out_dat_q, out_dat_d;
  logic [ssd_pkg::CH_IN_W-1:0]   out_ch_q;
  logic                          raw_v, first_v, second_v;

  assign s_axis_tready_o = (state_q == ssd_pkg::S_IDLE);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign ch_ext     = {5'b0, s_axis_tuser_i};
  assign in_range_d = (32'(s_axis_tuser_i) < CHANNELS);
  assign out_free   = !out_vld_q || m_axis_tready_i;

  assign eps     = (weight_q > ssd_pkg::ONE_Q16) ? ssd_pkg::ONE_Q16 : weight_q;
  assign samp_fx = {samp_q, 16'b0};
  assign last_d   = chan_vld_q[addr_q] ? signed'(ram_rdata[VW-1:0]) : '0;
  assign before_d = chan_vld_q[addr_q] ? signed'(ram_rdata[RAM_W-1:VW]) : '0;

  assign prod_d = mul_a * mul_b;
  assign rs16   = (prod_q + PW'(32768)) >>> 16;
  assign rs8    = (prod_q + PW'(128)) >>> 8;
  assign now_d  = ssd_pkg::sat32(rs16[ssd_pkg::SAT_IN_W-1:0]
                                 + ssd_pkg::SAT_IN_W'(last_q));
  assign d2_d   = ssd_pkg::sat32(rs8[ssd_pkg::SAT_IN_W-1:0]);

  always_comb begin
    state_d  = state_q;
    mul_a    = AW'(now_q) - AW'(before_q);
    mul_b    = signed'({2'b0, scale_q});
    out_load = 1'b0;
    ram_we   = 1'b0;
    unique case (state_q)
      ssd_pkg::S_IDLE: begin
        if (in_acc) state_d = ssd_pkg::S_LOAD;
      end
      ssd_pkg::S_LOAD: begin
        mul_a   = AW'(samp_fx) - AW'(last_d);
        mul_b   = signed'({1'b0, eps});
        state_d = ssd_pkg::S_NOW;
      end
      ssd_pkg::S_NOW: begin
        state_d = ssd_pkg::S_D1;
      end
      ssd_pkg::S_D1: begin
        state_d = ssd_pkg::S_D2;
      end
      ssd_pkg::S_D2: begin
        mul_a   = AW'(now_q) - (AW'(last_q) <<< 1) + AW'(before_q);
        state_d = ssd_pkg::S_DONE;
      end
      ssd_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = in_range_q;
          state_d  = ssd_pkg::S_IDLE;
        end
      end
      default: state_d = ssd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // second-difference product holds while the result waits
    if (state_q != ssd_pkg::S_DONE) prod_q <= prod_d;
    if (in_acc) begin
      addr_q     <= ch_ext[CH_W-1:0];
      in_range_q <= in_range_d;
      ch_q       <= s_axis_tuser_i;
      samp_q     <= signed'(s_axis_tdata_i);
    end
    if (state_q == ssd_pkg::S_LOAD) begin
      last_q   <= last_d;
      before_q <= before_d;
    end
    if (state_q == ssd_pkg::S_NOW) now_q <= now_d;
    if (state_q == ssd_pkg::S_D2) d1_q <= ssd_pkg::sat32(rs8[ssd_pkg::SAT_IN_W-1:0]);
    if (out_load) begin
      out_dat_q <= out_dat_d;
      out_ch_q  <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_vld_q <= '0;
    end else if (ram_we) begin
      chan_vld_q[addr_q] <= 1'b1;
    end
  end

  ssd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i ({last_q, now_q}),
    .re_i    (in_acc),
    .raddr_i (ch_ext[CH_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // output word; out-of-range channels give all-zero values and flags
  assign raw_v    = in_range_q && (en_raw_q || (!en_first_q && !en_second_q));
  assign first_v  = in_range_q && en_first_q;
  assign second_v = in_range_q && en_second_q;

  always_comb begin
    out_dat_d        = '0;
    out_dat_d[15:0]  = raw_v ? samp_q : '0;
    out_dat_d[16]    = raw_v;
    out_dat_d[48:17] = first_v ? d1_q : '0;
    out_dat_d[49]    = first_v;
    out_dat_d[81:50] = second_v ? d2_d : '0;
    out_dat_d[82]    = second_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tuser_o  = out_ch_q;

  // assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input accepted while a word is in progress");

  a_ram_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ssd_pkg::S_DONE) && in_range_q && out_free)
    else $error("history write outside completion");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ssd_pkg::S_DONE))
    else $error("result shown without a finished word");

endmodule

// ===== hdl/ssd_ram.sv =====
module ssd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
